>>> hw/rtl/chaotic_circuit_rk4_step_top_assert.svh
// assertion macros for the rk4 step block checker
// needs clk and rst_n in the scope where a macro is used
`ifndef CHAOTIC_CIRCUIT_RK4_STEP_TOP_ASSERT_SVH
`define CHAOTIC_CIRCUIT_RK4_STEP_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define CCRK_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CCRK_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ccrk_pkg.sv
// shared types, codes and helpers of the chua rk4 step block
// no dependencies
`timescale 1ns / 1ps

package ccrk_pkg;

    localparam int DW        = 32;   // state word
    localparam int OPW       = 34;   // multiplier operand
    localparam int PW        = 68;   // product and wide intermediates
    localparam int SUM_W     = 36;   // k0 + 2k1 + 2k2 + k3
    localparam int DIV_W     = 36;   // offset dividend of the divide by six
    localparam int DIV_DIG   = 4;    // quotient bits per cycle
    localparam int DIV_STEPS = DIV_W / DIV_DIG;
    localparam int QW        = 34;   // signed quotient
    localparam int CFG_AW    = 3;
    localparam int DIST_W    = 63;
    localparam int TDATA_IN  = 192;
    localparam int TDATA_OUT = 256;

    typedef enum logic [CFG_AW-1:0] {
        CFG_STEP_SIZE   = 3'd0,
        CFG_SLOPE_INNER = 3'd1,
        CFG_SLOPE_OUTER = 3'd2,
        CFG_BREAKPOINT  = 3'd3,
        CFG_INV_CAP_ONE = 3'd4,
        CFG_INV_CAP_TWO = 3'd5,
        CFG_INV_IND     = 3'd6
    } cfg_idx_t;

    // register values after reset
    localparam logic [30:0]        RST_STEP_SIZE   = 31'd503316;
    localparam logic signed [31:0] RST_SLOPE_INNER = -32'sd19176359;
    localparam logic signed [31:0] RST_SLOPE_OUTER = -32'sd11978932;
    localparam logic [30:0]        RST_BREAKPOINT  = 31'd16777216;
    localparam logic signed [31:0] RST_INV_CAP_ONE = 32'sd164418059;
    localparam logic signed [31:0] RST_INV_CAP_TWO = 32'sd16777216;
    localparam logic signed [31:0] RST_INV_IND     = 32'sd268435456;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT,
        OP_T1, OP_T2, OP_K0, OP_K1, OP_K2,
        OP_PX, OP_PY, OP_PZ,
        OP_ACC, OP_DSTART,
        OP_UX, OP_UY, OP_UZ,
        OP_DX, OP_DY, OP_DZ,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       particle;
        logic [1:0] stage;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    localparam logic signed [PW-1:0] S32_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PW-1:0] S32_MIN = {{(PW-31){1'b1}}, {31{1'b0}}};

    // saturate a wide signed value to 32 bits
    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > S32_MAX)
            r = S32_MAX[DW-1:0];
        else if (v < S32_MIN)
            r = S32_MIN[DW-1:0];
        else
            r = v[DW-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/ccrk_div6.sv
// iterative floor division by six, four quotient bits a cycle
// depends on ccrk_pkg
`timescale 1ns / 1ps

module ccrk_div6
    import ccrk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    output logic                    done,
    output logic signed [QW-1:0]    quotient
);

    localparam logic signed [SUM_W-1:0] OFFSET = 36'sd25769803776; // six times 2^32
    localparam logic [DIV_W:0]          UNBIAS = 37'd4294967296;   // 2^32

    logic                busy_reg;
    logic                done_reg;
    logic [3:0]          cnt_reg;
    logic [DIV_W-1:0]    shf_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [2:0]          rem_reg;
    logic [2:0]          rem_next;
    logic [DIV_DIG-1:0]  dig_next;
    logic [DIV_W:0]      q_wide;

    // one radix-16 digit: four restoring steps on a remainder below six
    always_comb
    begin
        logic [3:0] t;
        rem_next = rem_reg;
        dig_next = '0;
        for (int j = DIV_DIG - 1; j >= 0; j--)
        begin
            t = {rem_next, shf_reg[DIV_W-DIV_DIG+j]};
            if (t >= 4'd6)
            begin
                dig_next[j] = 1'b1;
                rem_next    = 3'(t - 4'd6);
            end
            else
            begin
                rem_next = t[2:0];
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'(DIV_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // dividend shifter, remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shf_reg <= $unsigned(dividend + OFFSET);
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            shf_reg <= shf_reg << DIV_DIG;
            quo_reg <= {quo_reg[DIV_W-DIV_DIG-1:0], dig_next};
            rem_reg <= rem_next;
        end
    end

    assign q_wide   = {1'b0, quo_reg} - UNBIAS;
    assign quotient = $signed(q_wide[QW-1:0]);
    assign done     = done_reg;

endmodule

>>> hw/rtl/ccrk_datapath.sv
// datapath: config registers, particle states, shared multiplier, rk4 work registers
// depends on ccrk_pkg and ccrk_div6
`timescale 1ns / 1ps

module ccrk_datapath
    import ccrk_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [DW-1:0]         cfg_data,
    input  logic [TDATA_IN-1:0]   load_data,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic [TDATA_OUT-1:0]  out_data
);

    localparam logic signed [PW-1:0] HALF_F = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF_H = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [PW-1:0]        MAX63  = {{(PW-DIST_W){1'b0}}, {DIST_W{1'b1}}};

    // configuration registers
    logic [30:0]        h_reg;
    logic signed [31:0] si_reg;
    logic signed [31:0] so_reg;
    logic [30:0]        bp_reg;
    logic signed [31:0] c1_reg;
    logic signed [31:0] c2_reg;
    logic signed [31:0] il_reg;

    // states and work registers
    logic signed [DW-1:0]    pa_reg  [3];
    logic signed [DW-1:0]    pb_reg  [3];
    logic signed [DW-1:0]    m_reg   [3];
    logic signed [DW-1:0]    k_reg   [3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [DW-1:0]    avg_reg [3];
    logic signed [PW-1:0]    diode_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [DW-1:0]    pq_reg;
    logic [1:0]              wb_idx_reg;
    op_t                     op_q_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic signed [DW-1:0]    out_reg [6];
    logic [DIST_W-1:0]       out_dist_reg;

    logic [1:0]              iss_idx;
    logic signed [OPW-1:0]   mul_a;
    logic signed [OPW-1:0]   mul_b;
    logic signed [PW-1:0]    mult;
    logic signed [PW-1:0]    rnd_f;
    logic signed [PW-1:0]    rnd_h;
    logic signed [OPW-1:0]   x34;
    logic signed [OPW-1:0]   bp34;
    logic signed [OPW-1:0]   clamp34;
    logic signed [DW-1:0]    p_sel;
    logic [DIST_W-1:0]       sq_sat;
    logic [DIST_W:0]         dist_sum;
    logic [DIST_W-1:0]       dist_base;
    logic                    div_start;
    logic                    div_done;
    logic signed [QW-1:0]    div_q;
    logic signed [SUM_W-1:0] div_in;

    // lane of the operation being issued
    always_comb
    begin
        case (cmd.op)
            OP_PY, OP_UY, OP_DY: iss_idx = 2'd1;
            OP_PZ, OP_UZ, OP_DZ: iss_idx = 2'd2;
            OP_DSTART:           iss_idx = cmd.lane;
            default:             iss_idx = 2'd0;
        endcase
    end

    // diode clamp of x to the breakpoint window
    always_comb
    begin
        x34  = OPW'(m_reg[0]);
        bp34 = $signed(OPW'(bp_reg));
        if (x34 > bp34)
            clamp34 = bp34;
        else if (x34 < -bp34)
            clamp34 = -bp34;
        else
            clamp34 = x34;
    end

    assign p_sel = cmd.particle ? pb_reg[iss_idx] : pa_reg[iss_idx];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_T1:
            begin
                mul_a = OPW'(so_reg);
                mul_b = OPW'(m_reg[0]);
            end
            OP_T2:
            begin
                mul_a = OPW'(si_reg) - OPW'(so_reg);
                mul_b = clamp34;
            end
            OP_K0:
            begin
                mul_a = OPW'(c1_reg);
                mul_b = OPW'(sat32(PW'(m_reg[1]) - PW'(m_reg[0]) - diode_reg));
            end
            OP_K1:
            begin
                mul_a = OPW'(c2_reg);
                mul_b = OPW'(sat32(PW'(m_reg[0]) - PW'(m_reg[1]) + PW'(m_reg[2])));
            end
            OP_K2:
            begin
                mul_a = OPW'(il_reg);
                mul_b = OPW'(m_reg[1]);
            end
            OP_PX, OP_PY, OP_PZ:
            begin
                mul_a = $signed(OPW'(h_reg));
                mul_b = OPW'(k_reg[iss_idx]);
            end
            OP_UX, OP_UY, OP_UZ:
            begin
                mul_a = $signed(OPW'(h_reg));
                mul_b = OPW'(avg_reg[iss_idx]);
            end
            OP_DX, OP_DY, OP_DZ:
            begin
                mul_a = OPW'(pa_reg[iss_idx]) - OPW'(pb_reg[iss_idx]);
                mul_b = OPW'(pa_reg[iss_idx]) - OPW'(pb_reg[iss_idx]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mult  = mul_a * mul_b;
    assign rnd_f = (prod_reg + HALF_F) >>> FRAC_BITS;
    assign rnd_h = (prod_reg + HALF_H) >>> (FRAC_BITS + 1);

    // squared difference and saturating distance sum
    assign sq_sat    = ($unsigned(prod_reg) > MAX63) ? MAX63[DIST_W-1:0] : prod_reg[DIST_W-1:0];
    assign dist_base = (wb_idx_reg == 2'd0) ? '0 : dist_reg;
    assign dist_sum  = {1'b0, dist_base} + {1'b0, sq_sat};

    // divide by six
    assign div_start = (cmd.op == OP_DSTART);
    assign div_in    = sum_reg[iss_idx] + SUM_W'(3);

    ccrk_div6 u_div6 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg  <= RST_STEP_SIZE;
            si_reg <= RST_SLOPE_INNER;
            so_reg <= RST_SLOPE_OUTER;
            bp_reg <= RST_BREAKPOINT;
            c1_reg <= RST_INV_CAP_ONE;
            c2_reg <= RST_INV_CAP_TWO;
            il_reg <= RST_INV_IND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_STEP_SIZE:   h_reg  <= cfg_data[30:0];
                CFG_SLOPE_INNER: si_reg <= $signed(cfg_data);
                CFG_SLOPE_OUTER: so_reg <= $signed(cfg_data);
                CFG_BREAKPOINT:  bp_reg <= cfg_data[30:0];
                CFG_INV_CAP_ONE: c1_reg <= $signed(cfg_data);
                CFG_INV_CAP_TWO: c2_reg <= $signed(cfg_data);
                CFG_INV_IND:     il_reg <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // particle states, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pa_reg[j] <= '0;
                pb_reg[j] <= '0;
            end
        end
        else
        begin
            if (cmd.op == OP_LOAD)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pa_reg[j] <= $signed(load_data[DW*j +: DW]);
                    pb_reg[j] <= $signed(load_data[DW*(j+3) +: DW]);
                end
            end
            if (op_q_reg == OP_UX || op_q_reg == OP_UY || op_q_reg == OP_UZ)
            begin
                if (cmd.particle)
                    pb_reg[wb_idx_reg] <= sat32(PW'(pq_reg) + rnd_f);
                else
                    pa_reg[wb_idx_reg] <= sat32(PW'(pq_reg) + rnd_f);
            end
        end
    end

    // operation tracking through the multiplier register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_q_reg <= OP_NONE;
        else
            op_q_reg <= cmd.op;
    end

    // multiplier register and work registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= mult;
        pq_reg     <= p_sel;
        wb_idx_reg <= iss_idx;

        // immediate operations
        case (cmd.op)
            OP_INIT:
            begin
                for (int j = 0; j < 3; j++)
                    m_reg[j] <= cmd.particle ? pb_reg[j] : pa_reg[j];
            end
            OP_PX, OP_PY, OP_PZ:
            begin
                if (cmd.stage == 2'd0)
                    sum_reg[iss_idx] <= SUM_W'(k_reg[iss_idx]);
                else
                    sum_reg[iss_idx] <= sum_reg[iss_idx] + (SUM_W'(k_reg[iss_idx]) <<< 1);
            end
            OP_ACC:
            begin
                for (int j = 0; j < 3; j++)
                    sum_reg[j] <= sum_reg[j] + SUM_W'(k_reg[j]);
            end
            OP_OUT:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    out_reg[j]   <= pa_reg[j];
                    out_reg[j+3] <= pb_reg[j];
                end
                out_dist_reg <= dist_reg;
            end
            default: ;
        endcase

        // writeback of the product issued in the previous cycle
        case (op_q_reg)
            OP_T1: diode_reg <= rnd_f;
            OP_T2: diode_reg <= diode_reg + rnd_f;
            OP_K0: k_reg[0]  <= sat32(rnd_f);
            OP_K1: k_reg[1]  <= sat32(rnd_f);
            OP_K2: k_reg[2]  <= sat32(-rnd_f);
            OP_PX, OP_PY, OP_PZ:
            begin
                if (cmd.stage == 2'd2)
                    m_reg[wb_idx_reg] <= sat32(PW'(pq_reg) + rnd_f);
                else
                    m_reg[wb_idx_reg] <= sat32(PW'(pq_reg) + rnd_h);
            end
            OP_DX, OP_DY, OP_DZ:
                dist_reg <= dist_sum[DIST_W] ? MAX63[DIST_W-1:0] : dist_sum[DIST_W-1:0];
            default: ;
        endcase

        // averaged slope from the divider
        if (div_done)
            avg_reg[cmd.lane] <= sat32(PW'(div_q));
    end

    assign stat.div_done = div_done;

    assign out_data = {1'b0, out_dist_reg,
                       out_reg[5], out_reg[4], out_reg[3],
                       out_reg[2], out_reg[1], out_reg[0]};

endmodule

>>> hw/rtl/ccrk_ctrl.sv
// controller: sequences load, four rk4 stages per particle, averaging and distance
// depends on ccrk_pkg
`timescale 1ns / 1ps

module ccrk_ctrl
    import ccrk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  req_load,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_DERIV = 9'b000000100,
        S_POINT = 9'b000001000,
        S_ACC   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_DIST  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] stage_reg, stage_next;
    logic [1:0] lane_reg, lane_next;
    logic       part_reg, part_next;
    logic       ovalid_reg, ovalid_next;

    // next state and command
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        stage_next  = stage_reg;
        lane_next   = lane_reg;
        part_next   = part_reg;
        ovalid_next = ovalid_reg && !m_tready;
        s_tready    = 1'b0;

        cmd.op       = OP_NONE;
        cmd.particle = part_reg;
        cmd.stage    = stage_reg;
        cmd.lane     = lane_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    step_next = '0;
                    if (req_load)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_DIST;
                    end
                    else
                    begin
                        part_next  = 1'b0;
                        stage_next = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                step_next  = '0;
                state_next = S_DERIV;
            end
            S_DERIV:
            begin
                if (!step_reg[0])
                begin
                    case (step_reg[3:1])
                        3'd0:    cmd.op = OP_T1;
                        3'd1:    cmd.op = OP_T2;
                        3'd2:    cmd.op = OP_K0;
                        3'd3:    cmd.op = OP_K1;
                        3'd4:    cmd.op = OP_K2;
                        default: cmd.op = OP_NONE;
                    endcase
                end
                if (step_reg == 4'd9)
                begin
                    step_next  = '0;
                    state_next = (stage_reg == 2'd3) ? S_ACC : S_POINT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_POINT:
            begin
                if (!step_reg[0])
                begin
                    case (step_reg[2:1])
                        2'd0:    cmd.op = OP_PX;
                        2'd1:    cmd.op = OP_PY;
                        2'd2:    cmd.op = OP_PZ;
                        default: cmd.op = OP_NONE;
                    endcase
                end
                if (step_reg == 4'd5)
                begin
                    step_next  = '0;
                    stage_next = stage_reg + 2'd1;
                    state_next = S_DERIV;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                lane_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 4'd0)
                begin
                    cmd.op    = OP_DSTART;
                    step_next = 4'd1;
                end
                else if (stat.div_done)
                begin
                    step_next = '0;
                    if (lane_reg == 2'd2)
                        state_next = S_UPD;
                    else
                        lane_next = lane_reg + 2'd1;
                end
            end
            S_UPD:
            begin
                if (!step_reg[0])
                begin
                    case (step_reg[2:1])
                        2'd0:    cmd.op = OP_UX;
                        2'd1:    cmd.op = OP_UY;
                        2'd2:    cmd.op = OP_UZ;
                        default: cmd.op = OP_NONE;
                    endcase
                end
                if (step_reg == 4'd5)
                begin
                    step_next = '0;
                    if (!part_reg)
                    begin
                        part_next  = 1'b1;
                        stage_next = '0;
                        state_next = S_INIT;
                    end
                    else
                    begin
                        state_next = S_DIST;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_DIST:
            begin
                if (!step_reg[0])
                begin
                    case (step_reg[2:1])
                        2'd0:    cmd.op = OP_DX;
                        2'd1:    cmd.op = OP_DY;
                        2'd2:    cmd.op = OP_DZ;
                        default: cmd.op = OP_NONE;
                    endcase
                end
                if (step_reg == 4'd5)
                begin
                    step_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_OUT:
            begin
                // output register free or being emptied this cycle
                if (!ovalid_reg || m_tready)
                begin
                    cmd.op      = OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            stage_reg  <= '0;
            lane_reg   <= '0;
            part_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            stage_reg  <= stage_next;
            lane_reg   <= lane_next;
            part_reg   <= part_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;

endmodule

>>> hw/rtl/chaotic_circuit_rk4_step_top.sv
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+---------------------------------------------
// s_        | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata six load words
// m_        | out | m_tvalid/m_tready  | m_tdata six state words, distance_sq
// cfg_      | in  | cfg_we             | cfg_addr register index, cfg_data value
//
// in a step item one 34x34 multiplier is shared by every product of the four stages
// of both particles, and each particle takes three runs of the radix-16 divide by six
// one item is in work at a time
// the output register holds a result until taken, so the next item is accepted meanwhile
// asynchronous active-low reset clears the states to zero and the registers to defaults
// top level of the chua rk4 step block
// depends on ccrk_pkg, ccrk_ctrl, ccrk_datapath
`timescale 1ns / 1ps

module chaotic_circuit_rk4_step_top
    import ccrk_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_IN-1:0]   s_tdata,   // load_a_x, load_a_y, load_a_z, load_b_x, load_b_y, load_b_z
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_OUT-1:0]  m_tdata,   // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, distance_sq
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [DW-1:0]         cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    ccrk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_load (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    ccrk_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .load_data (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata)
    );

endmodule

>>> hw/rtl/ccrk_checker.sv
// port-level checks of the chua rk4 step block, bound to the top level
// depends on chaotic_circuit_rk4_step_top_assert.svh
`timescale 1ns / 1ps
`include "chaotic_circuit_rk4_step_top_assert.svh"

module ccrk_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);

    // a waiting result stays offered
    `CCRK_AST_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a waiting result keeps its data
    `CCRK_AST_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // one item in work at a time
    `CCRK_AST_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // a result only appears after a spell of work with the input closed
    `CCRK_AST_NOW(a_result_after_work, $rose(m_tvalid), !$past(s_tready), "result without work")

endmodule

bind chaotic_circuit_rk4_step_top ccrk_checker u_ccrk_checker (.*);

>>> sim/tb.sv
// self-checking testbench for the chua rk4 step block: directed table, then random
// transactions, each result checked against an in-bench fixed-point predictor
// depends on ccrk_pkg and chaotic_circuit_rk4_step_top
`timescale 1ns / 1ps

module tb;
    import ccrk_pkg::*;

    localparam int FRAC = 24;
    localparam int STEP_LAT = 260;
    localparam longint MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic { REQ_STEP = 1'b0, REQ_LOAD = 1'b1 } req_t;

    typedef struct {
        logic [31:0] ax, ay, az, bx, by, bz;
        logic [62:0] dist_sq;
    } state_report_t;

    typedef struct {
        req_t        kind;
        logic [31:0] w [6];
        bit          fixed;      // expected distance typed in the table
        logic [62:0] dist_sq;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_IN-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_OUT-1:0] m_tdata;
    logic cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [DW-1:0] cfg_data;

    chaotic_circuit_rk4_step_top #(.FRAC_BITS(FRAC)) dut (.*);

    // predictor copy of registers and trajectories
    longint h, g_in, g_out, bp, c1, c2, ind;
    longint pa [3];
    longint pb [3];

    state_report_t expected_reports [$];
    int  fail_count;
    bit  stim_done;
    bit  calm;           // no idling in the final stretch
    bit  hold_sink;      // long receiver hold-off request
    longint taken;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // exact product, round half up, arithmetic shift
    function automatic longint rnd_mul(longint a, longint b, int s);
        longint p;
        p = a * b + (longint'(1) << (s - 1));
        return p >>> s;
    endfunction

    function automatic void slope_of(input longint p [3], output longint d [3]);
        longint c;
        longint diode;
        c = p[0];
        if (c > bp)
            c = bp;
        if (c < -bp)
            c = -bp;
        diode = rnd_mul(g_out, p[0], FRAC) + rnd_mul(g_in - g_out, c, FRAC);
        d[0] = clip32(rnd_mul(c1, clip32((p[1] - p[0]) - diode), FRAC));
        d[1] = clip32(rnd_mul(c2, clip32((p[0] - p[1]) + p[2]), FRAC));
        d[2] = clip32(-rnd_mul(ind, p[1], FRAC));
    endfunction

    function automatic longint sixth_rounded(longint n);
        longint v;
        v = n + 3;
        if (v >= 0)
            return v / 6;
        return -((-v + 5) / 6);
    endfunction

    function automatic void advance(inout longint p [3]);
        longint k0 [3], k1 [3], k2 [3], k3 [3], m [3];
        longint s;
        slope_of(p, k0);
        foreach (m[i]) m[i] = clip32(p[i] + rnd_mul(h, k0[i], FRAC + 1));
        slope_of(m, k1);
        foreach (m[i]) m[i] = clip32(p[i] + rnd_mul(h, k1[i], FRAC + 1));
        slope_of(m, k2);
        foreach (m[i]) m[i] = clip32(p[i] + rnd_mul(h, k2[i], FRAC));
        slope_of(m, k3);
        foreach (p[i])
        begin
            s = k0[i] + 2 * k1[i] + 2 * k2[i] + k3[i];
            p[i] = clip32(p[i] + rnd_mul(h, clip32(sixth_rounded(s)), FRAC));
        end
    endfunction

    function automatic state_report_t predict(req_t kind, logic [31:0] w [6]);
        state_report_t r;
        longint d;
        longint sum;
        longint sq;
        if (kind == REQ_LOAD)
        begin
            foreach (pa[i])
            begin
                pa[i] = longint'(signed'(w[i]));
                pb[i] = longint'(signed'(w[3 + i]));
            end
        end
        else
        begin
            advance(pa);
            advance(pb);
        end
        sum = 0;
        foreach (pa[i])
        begin
            d = pa[i] - pb[i];
            sq = d * d;                  // fits unsigned 64; clip at 2^63-1
            if (sq < 0)
                sq = MAX63;
            sum = sum + sq;
            if (sum < 0)
                sum = MAX63;
        end
        r.ax = pa[0][31:0]; r.ay = pa[1][31:0]; r.az = pa[2][31:0];
        r.bx = pb[0][31:0]; r.by = pb[1][31:0]; r.bz = pb[2][31:0];
        r.dist_sq = sum[62:0];
        return r;
    endfunction

    // register write, predictor copy updated alongside
    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_STEP_SIZE:   h = longint'(v[30:0]);
            CFG_SLOPE_INNER: g_in = longint'(signed'(v));
            CFG_SLOPE_OUTER: g_out = longint'(signed'(v));
            CFG_BREAKPOINT:  bp = longint'(v[30:0]);
            CFG_INV_CAP_ONE: c1 = longint'(signed'(v));
            CFG_INV_CAP_TWO: c2 = longint'(signed'(v));
            CFG_INV_IND:     ind = longint'(signed'(v));
            default:         ;
        endcase
    endtask

    task automatic drain;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (STEP_LAT) @(negedge clk);
    endtask

    // drive one transaction; valid stays high across back-to-back items
    task automatic send(req_t kind, logic [31:0] w [6], bit idle_ok);
        if (idle_ok && !calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {w[5], w[4], w[3], w[2], w[1], w[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_reports.push_back(predict(kind, w));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    // receiver with random stalls and a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_tready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_sink = 1'b0;
            end
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // result checking
    always @(posedge clk)
    begin
        state_report_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            taken <= taken + 1;
            if (expected_reports.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                e = expected_reports.pop_front();
                if (m_tdata[31:0] !== e.ax)
                begin
                    $error("out_a_x exp %h got %h", e.ax, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== e.ay)
                begin
                    $error("out_a_y exp %h got %h", e.ay, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== e.az)
                begin
                    $error("out_a_z exp %h got %h", e.az, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tdata[127:96] !== e.bx)
                begin
                    $error("out_b_x exp %h got %h", e.bx, m_tdata[127:96]);
                    fail_count++;
                end
                if (m_tdata[159:128] !== e.by)
                begin
                    $error("out_b_y exp %h got %h", e.by, m_tdata[159:128]);
                    fail_count++;
                end
                if (m_tdata[191:160] !== e.bz)
                begin
                    $error("out_b_z exp %h got %h", e.bz, m_tdata[191:160]);
                    fail_count++;
                end
                if (m_tdata[254:192] !== e.dist_sq)
                begin
                    $error("distance_sq exp %h got %h", e.dist_sq, m_tdata[254:192]);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2_000_000_000;
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        table_row_t rows [$];
        table_row_t r;
        logic [31:0] w [6];
        int n;
        int mode;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = REQ_STEP;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_STEP_SIZE;
        cfg_data = '0;
        fail_count = 0;
        stim_done = 1'b0;
        calm = 1'b0;
        hold_sink = 1'b0;
        taken = 0;
        h = longint'(RST_STEP_SIZE);
        g_in = longint'(RST_SLOPE_INNER);
        g_out = longint'(RST_SLOPE_OUTER);
        bp = longint'(RST_BREAKPOINT);
        c1 = longint'(RST_INV_CAP_ONE);
        c2 = longint'(RST_INV_CAP_TWO);
        ind = longint'(RST_INV_IND);
        foreach (pa[i])
        begin
            pa[i] = 0;
            pb[i] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: rows with a typed distance are checked against it too
        r.fixed = 1'b1; r.dist_sq = '0; r.kind = REQ_STEP;
        foreach (r.w[i]) r.w[i] = '0;
        rows.push_back(r);                                   // step from zero state
        r.kind = REQ_LOAD;
        rows.push_back(r);                                   // load all zero
        r.w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        r.dist_sq = 63'h7FFF_FFFF_FFFF_FFFF;                 // saturated distance
        rows.push_back(r);
        r.fixed = 1'b0; r.kind = REQ_STEP;
        rows.push_back(r);                                   // step at extremes
        rows.push_back(r);
        r.fixed = 1'b1; r.kind = REQ_LOAD;
        r.w = '{32'h0100_0000, 0, 0, 0, 0, 0};
        r.dist_sq = 63'h1_0000_0000_0000;                    // one squared, Q15.48
        rows.push_back(r);
        r.fixed = 1'b0; r.kind = REQ_STEP;
        for (int i = 0; i < 6; i++) rows.push_back(r);
        r.kind = REQ_LOAD;
        r.w = '{32'hFF00_0000, 32'h0080_0000, 32'hFFF0_0000,
                32'h00FF_0000, 32'hFF80_0000, 32'h0010_0000};
        rows.push_back(r);
        r.kind = REQ_STEP;
        r.w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; // ignored on a step
        for (int i = 0; i < 5; i++) rows.push_back(r);

        foreach (rows[i])
        begin
            send(rows[i].kind, rows[i].w, 1'b1);
            if (rows[i].fixed && expected_reports[$].dist_sq !== rows[i].dist_sq)
            begin
                $error("distance_sq table %h predictor %h",
                       rows[i].dist_sq, expected_reports[$].dist_sq);
                fail_count++;
            end
        end
        s_tvalid = 1'b0;

        // random phases over register settings, extremes first
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_reg(CFG_STEP_SIZE, 32'h7FFF_FFFF);
                    write_reg(CFG_SLOPE_INNER, 32'h7FFF_FFFF);
                    write_reg(CFG_SLOPE_OUTER, 32'h8000_0000);
                    write_reg(CFG_BREAKPOINT, 32'h7FFF_FFFF);
                    write_reg(CFG_INV_CAP_ONE, 32'h8000_0000);
                    write_reg(CFG_INV_CAP_TWO, 32'h7FFF_FFFF);
                    write_reg(CFG_INV_IND, 32'h8000_0000);
                end
                1:
                begin
                    write_reg(CFG_STEP_SIZE, 32'h0);
                    write_reg(CFG_SLOPE_INNER, 32'h8000_0000);
                    write_reg(CFG_SLOPE_OUTER, 32'h7FFF_FFFF);
                    write_reg(CFG_BREAKPOINT, 32'h0);
                    write_reg(CFG_INV_CAP_ONE, 32'h7FFF_FFFF);
                    write_reg(CFG_INV_CAP_TWO, 32'h8000_0000);
                    write_reg(CFG_INV_IND, 32'h7FFF_FFFF);
                end
                2, 7:
                begin
                    // nominal circuit
                    write_reg(CFG_STEP_SIZE, 32'(RST_STEP_SIZE));
                    write_reg(CFG_SLOPE_INNER, RST_SLOPE_INNER);
                    write_reg(CFG_SLOPE_OUTER, RST_SLOPE_OUTER);
                    write_reg(CFG_BREAKPOINT, 32'(RST_BREAKPOINT));
                    write_reg(CFG_INV_CAP_ONE, RST_INV_CAP_ONE);
                    write_reg(CFG_INV_CAP_TWO, RST_INV_CAP_TWO);
                    write_reg(CFG_INV_IND, RST_INV_IND);
                end
                default:
                begin
                    for (int k = 0; k < 7; k++)
                        write_reg(cfg_idx_t'(k), $urandom());
                    write_reg(CFG_STEP_SIZE, $urandom_range(0, 1 << 24));
                end
            endcase
            if (ph == 3)
                hold_sink = 1'b1;
            if (ph == 7)
                calm = 1'b1;
            n = 210;
            for (int j = 0; j < n; j++)
            begin
                // mostly long step runs from a random load, some noise loads
                if (j % 30 == 0 || $urandom_range(0, 19) == 0)
                begin
                    mode = $urandom_range(0, 3);
                    foreach (w[i]) w[i] = rand_word(mode);
                    send(REQ_LOAD, w, 1'b1);
                end
                else
                begin
                    foreach (w[i]) w[i] = $urandom();
                    send(REQ_STEP, w, 1'b1);
                end
                if (j == 100)
                begin
                    // sender pause until every result is in
                    s_tvalid = 1'b0;
                    while (expected_reports.size() != 0)
                        @(negedge clk);
                end
            end
            s_tvalid = 1'b0;
        end

        stim_done = 1'b1;
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
